@@ hdl/multi_channel_pulse_tachometer_unit_assert.svh @@
// Assertion macros shared by the tachometer RTL files.
`ifndef MULTI_CHANNEL_PULSE_TACHOMETER_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_PULSE_TACHOMETER_UNIT_ASSERT_SVH

// Property checked at every rising edge outside reset.
`define MCPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define MCPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mcpt_pkg.sv @@
// Package of types and constants shared by the tachometer modules.
`default_nettype none

package mcpt_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int MAX_REPORT       = 4;

    localparam int CH_FIELD_W = 2;
    localparam int TS_W       = 32;
    localparam int PPR_W      = 16;
    localparam int RPM_W      = 26;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [RPM_W-1:0] RPM_NUMERATOR = 26'd60000000;
    localparam logic [PPR_W-1:0] PPR_RESET     = 16'd1;
    localparam logic [TS_W-1:0]  TIMEOUT_RESET = 32'd500000;

    // One quotient bit per divider step.
    localparam int DIV_STEPS = RPM_W;

    // Command queue depth, a power of two.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PPR     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

    typedef enum logic [0:0] {
        CMD_PULSE = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd_kind;

    // Queue entry: the command with the configuration in force when it arrived.
    typedef struct packed {
        t_cmd_kind              kind;
        logic [CH_FIELD_W-1:0]  channel;
        logic [TS_W-1:0]        timestamp;
        logic [PPR_W-1:0]       ppr;
        logic [TS_W-1:0]        timeout;
    } t_cmd;

endpackage

`default_nettype wire

@@ hdl/multi_channel_pulse_tachometer_unit.sv @@
// Top level of the multi-channel pulse tachometer.
// Usage: the input channel (i_in_valid / o_in_stall) carries transactions of two kinds.
// A pulse transaction (command 0) marks a rising edge on one motor channel, stamped
// in microseconds; it yields no output. When a channel's pulse count reaches the
// pulses-per-revolution setting, 60000000 is divided by the elapsed time to give rpm.
// A tick transaction (command 1) stops every channel idle for longer than the timeout
// and then reports channels 0 to three as four output transactions on o_out_valid /
// i_out_stall, the last one flagged by o_last_of_report.
// A queued pulse passes through the back end's idle and pulse states, and through the
// divide state too when a revolution with a non-zero period completes, as the serial
// divider yields one quotient bit per cycle. A tick steps through the channels in turn
// in the scan state, which registers each report. A two-entry queue parts
// the front end from the back end, so o_in_stall rises only while that queue is full.
// Reset (synchronous, active low) marks every channel stopped with zero speed and
// loads the configuration defaults. A stalled receiver holds the output register and
// pauses the report scan; pulses keep filling the queue until it is full.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; each queued
// transaction carries the settings in force when it was accepted.
`default_nettype none

module multi_channel_pulse_tachometer_unit #(
    parameter int NUM_CHANNELS = mcpt_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_command,
    input  wire logic [mcpt_pkg::CH_FIELD_W-1:0]   i_channel,
    input  wire logic [mcpt_pkg::TS_W-1:0]         i_timestamp_us,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [mcpt_pkg::CH_FIELD_W-1:0]        o_report_channel,
    output logic [mcpt_pkg::RPM_W-1:0]             o_speed_rpm,
    output logic                                   o_stopped,
    output logic                                   o_last_of_report,
    input  wire logic                              i_cfg_we,
    input  wire logic [mcpt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mcpt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    mcpt_pkg::t_cmd  cmd_in;
    mcpt_pkg::t_cmd  cmd_head;

    // The input side stalls only when the command queue has no room.
    assign o_in_stall = full;

    mcpt_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_command      (i_command),
        .i_channel      (i_channel),
        .i_timestamp_us (i_timestamp_us),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (cmd_in)
    );

    mcpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (cmd_head)
    );

    // The back end owns all channel state, so pulses and ticks are applied in order.
    mcpt_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_head           (cmd_head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_report_channel (o_report_channel),
        .o_speed_rpm      (o_speed_rpm),
        .o_stopped        (o_stopped),
        .o_last_of_report (o_last_of_report)
    );

endmodule

`default_nettype wire

@@ hdl/mcpt_front.sv @@
// Front end: configuration registers, input acceptance and command classification.
`default_nettype none

module mcpt_front #(
    parameter int NUM_CHANNELS = mcpt_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_command,
    input  wire logic [mcpt_pkg::CH_FIELD_W-1:0]     i_channel,
    input  wire logic [mcpt_pkg::TS_W-1:0]           i_timestamp_us,
    input  wire logic                                i_cfg_we,
    input  wire logic [mcpt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mcpt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_full,
    output logic                                     o_push,
    output mcpt_pkg::t_cmd                           o_cmd
);

    logic [mcpt_pkg::PPR_W-1:0] r_ppr;
    logic [mcpt_pkg::TS_W-1:0]  r_timeout;
    logic                       keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr     <= mcpt_pkg::PPR_RESET;
            r_timeout <= mcpt_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mcpt_pkg::CFG_PPR:     r_ppr     <= i_cfg_data[mcpt_pkg::PPR_W-1:0];
                mcpt_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[mcpt_pkg::TS_W-1:0];
            endcase
        end
    end

    // Pulses on channels that do not exist are accepted and dropped here.
    assign keep = (mcpt_pkg::t_cmd_kind'(i_command) == mcpt_pkg::CMD_TICK) ||
                  (32'(i_channel) < NUM_CHANNELS);

    assign o_push          = i_in_valid && !i_full && keep;
    assign o_cmd.kind      = mcpt_pkg::t_cmd_kind'(i_command);
    assign o_cmd.channel   = i_channel;
    assign o_cmd.timestamp = i_timestamp_us;
    assign o_cmd.ppr       = r_ppr;
    assign o_cmd.timeout   = r_timeout;

endmodule

`default_nettype wire

@@ hdl/mcpt_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none

module mcpt_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mcpt_pkg::t_cmd  i_cmd,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output mcpt_pkg::t_cmd       o_head
);

    `include "multi_channel_pulse_tachometer_unit_assert.svh"

    localparam int PTR_W = $clog2(mcpt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mcpt_pkg::QUEUE_DEPTH + 1);

    mcpt_pkg::t_cmd    r_mem [mcpt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_full  = (r_count == CNT_W'(mcpt_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    `MCPT_ASSERT(a_no_push_full, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `MCPT_ASSERT(a_no_pop_empty, i_clk, i_rst_n, !(i_pop && o_empty), "pop from empty queue")

endmodule

`default_nettype wire

@@ hdl/mcpt_back.sv @@
// Back end: per-channel state, serial rpm divider and tick report sequencer.
`default_nettype none

module mcpt_back #(
    parameter int NUM_CHANNELS = mcpt_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_empty,
    input  wire mcpt_pkg::t_cmd                    i_head,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [mcpt_pkg::CH_FIELD_W-1:0]        o_report_channel,
    output logic [mcpt_pkg::RPM_W-1:0]             o_speed_rpm,
    output logic                                   o_stopped,
    output logic                                   o_last_of_report
);

    `include "multi_channel_pulse_tachometer_unit_assert.svh"

    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int REPORT_COUNT = (NUM_CHANNELS < mcpt_pkg::MAX_REPORT) ?
                                  NUM_CHANNELS : mcpt_pkg::MAX_REPORT;
    localparam int STEP_W       = $clog2(mcpt_pkg::DIV_STEPS);
    localparam int TS_W         = mcpt_pkg::TS_W;
    localparam int RPM_W        = mcpt_pkg::RPM_W;
    localparam int PPR_W        = mcpt_pkg::PPR_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PULSE,
        S_DIV,
        S_SCAN
    } t_state;

    t_state             r_state;
    mcpt_pkg::t_cmd     r_cmd;
    logic [CH_W-1:0]    r_idx;
    logic [STEP_W-1:0]  r_step;
    logic [TS_W-1:0]    r_den;
    logic [RPM_W-1:0]   r_rem;
    logic [RPM_W-1:0]   r_quo;

    logic [TS_W-1:0]    r_start   [NUM_CHANNELS];
    logic [PPR_W-1:0]   r_count   [NUM_CHANNELS];
    logic               r_stop    [NUM_CHANNELS];
    logic [RPM_W-1:0]   r_rpm     [NUM_CHANNELS];

    logic                             r_out_valid;
    logic [mcpt_pkg::CH_FIELD_W-1:0]  r_out_channel;
    logic [RPM_W-1:0]                 r_out_rpm;
    logic                             r_out_stopped;
    logic                             r_out_last;

    logic [CH_W-1:0]   ch_sel;
    logic [TS_W-1:0]   p_start;
    logic [PPR_W-1:0]  p_count;
    logic              p_done;
    logic [TS_W-1:0]   p_elapsed;
    logic [TS_W-1:0]   s_elapsed;
    logic              s_timeout;
    logic              s_report;
    logic              s_last;
    logic              s_end;
    logic              out_free;
    logic [RPM_W:0]    d_trial;
    logic              d_ge;
    logic [RPM_W:0]    d_diff;

    assign ch_sel    = CH_W'(r_cmd.channel);
    assign p_start   = r_stop[ch_sel] ? r_cmd.timestamp : r_start[ch_sel];
    assign p_count   = r_count[ch_sel] + PPR_W'(1);
    assign p_done    = (p_count == r_cmd.ppr);
    assign p_elapsed = r_cmd.timestamp - p_start;

    assign s_elapsed = r_cmd.timestamp - r_start[r_idx];
    assign s_timeout = (s_elapsed > r_cmd.timeout);
    assign s_report  = (32'(r_idx) < REPORT_COUNT);
    assign s_last    = (32'(r_idx) == REPORT_COUNT - 1);
    assign s_end     = (32'(r_idx) == NUM_CHANNELS - 1);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Restoring division, one quotient bit per cycle; the dividend shifts out of r_quo.
    assign d_trial = {r_rem, r_quo[RPM_W-1]};
    assign d_ge    = (TS_W'(d_trial) >= r_den);
    assign d_diff  = d_trial - r_den[RPM_W:0];

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_start[i] <= '0;
                r_count[i] <= '0;
                r_stop[i]  <= 1'b1;
                r_rpm[i]   <= '0;
            end
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_head;
                        r_idx <= '0;
                        r_state <= (i_head.kind == mcpt_pkg::CMD_TICK) ? S_SCAN : S_PULSE;
                    end
                end
                S_PULSE: begin
                    r_stop[ch_sel] <= 1'b0;
                    if (p_done) begin
                        r_start[ch_sel] <= r_cmd.timestamp;
                        r_count[ch_sel] <= '0;
                        if (p_elapsed == '0) begin
                            r_rpm[ch_sel] <= mcpt_pkg::RPM_NUMERATOR;
                            r_state       <= S_IDLE;
                        end else begin
                            r_den   <= p_elapsed;
                            r_rem   <= '0;
                            r_quo   <= mcpt_pkg::RPM_NUMERATOR;
                            r_step  <= '0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_start[ch_sel] <= p_start;
                        r_count[ch_sel] <= p_count;
                        r_state         <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_rem <= d_ge ? d_diff[RPM_W-1:0] : d_trial[RPM_W-1:0];
                    r_quo <= {r_quo[RPM_W-2:0], d_ge};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(mcpt_pkg::DIV_STEPS - 1)) begin
                        r_rpm[ch_sel] <= {r_quo[RPM_W-2:0], d_ge};
                        r_state       <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (!s_report || out_free) begin
                        if (s_timeout) begin
                            r_stop[r_idx]  <= 1'b1;
                            r_count[r_idx] <= '0;
                            r_rpm[r_idx]   <= '0;
                        end
                        if (s_report) begin
                            r_out_valid   <= 1'b1;
                            r_out_channel <= mcpt_pkg::CH_FIELD_W'(r_idx);
                            r_out_rpm     <= s_timeout ? '0 : r_rpm[r_idx];
                            r_out_stopped <= s_timeout || r_stop[r_idx];
                            r_out_last    <= s_last;
                        end
                        if (s_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + CH_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_report_channel = r_out_channel;
    assign o_speed_rpm      = r_out_rpm;
    assign o_stopped        = r_out_stopped;
    assign o_last_of_report = r_out_last;

    `MCPT_ASSERT(a_div_nonzero, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_den != '0), "divide by zero entered")
    `MCPT_ASSERT(a_div_steps, i_clk, i_rst_n, (r_state == S_DIV) |-> (32'(r_step) < mcpt_pkg::DIV_STEPS), "divider overran")
    `MCPT_ASSERT(a_stop_zero, i_clk, i_rst_n, (r_out_valid && r_out_stopped) |-> (r_out_rpm == '0), "stopped channel with speed")

endmodule

`default_nettype wire
